@@ hdl/assert_macros.svh @@
// Assertion macros shared by the log record deframer RTL
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on every rising edge while out of reset
`define LRD_ASSERT(lbl, clk, rstn, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
		else $error("lrd assertion failed");

// Antecedent in one cycle implies consequent in the next
`define LRD_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
		else $error("lrd assertion failed");

`endif

@@ hdl/lrd_pkg.sv @@
// Types, codes and the CRC32C byte update for the log record deframer
package lrd_pkg;

	localparam int unsigned HDR_BYTES   = 8;
	localparam logic [31:0] DEFAULT_CAP = 32'd67108864;
	localparam logic [31:0] CRC_POLY    = 32'h82F63B78;
	localparam logic [31:0] CRC_INIT    = 32'hFFFFFFFF;

	// Result kinds
	localparam logic [1:0] KIND_PAYLOAD = 2'd0;
	localparam logic [1:0] KIND_ACCEPT  = 2'd1;
	localparam logic [1:0] KIND_REJECT  = 2'd2;
	localparam logic [1:0] KIND_SUMMARY = 2'd3;

	// Framer phases
	localparam logic [1:0] PH_HEADER   = 2'd0;
	localparam logic [1:0] PH_PAYLOAD  = 2'd1;
	localparam logic [1:0] PH_REJECTED = 2'd2;

	typedef struct packed {
		logic       present;
		logic [7:0] data;
		logic       last;
	} item_t;

	typedef struct packed {
		logic [1:0]  kind;
		logic [7:0]  payload_byte;
		logic [31:0] record_length;
		logic [47:0] accepted_bytes;
		logic [31:0] record_count;
		logic        truncated;
		logic        discarded;
		logic        run_last;
	} res_t;

	// Up to three results per item, entry 0 goes out first
	typedef struct packed {
		res_t [2:0] res;
		logic [1:0] cnt;
	} bundle_t;

	// Reflected CRC32C, one byte, bit at a time unrolled
	function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] b);
		logic [31:0] c;
		c = crc ^ {24'd0, b};
		for (int i = 0; i < 8; i++) begin
			c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
		end
		return c;
	endfunction

	function automatic res_t mk_res(input logic [1:0] kind, input logic [7:0] pbyte,
			input logic [31:0] rlen, input logic [47:0] vb, input logic [31:0] rc,
			input logic tr, input logic di);
		res_t r;
		r.kind           = kind;
		r.payload_byte   = pbyte;
		r.record_length  = rlen;
		r.accepted_bytes = vb;
		r.record_count   = rc;
		r.truncated      = tr;
		r.discarded      = di;
		r.run_last       = 1'b0;
		return r;
	endfunction

endpackage

@@ hdl/lrd_framer.sv @@
// Record framing state, CRC check and result generation for one item per cycle while fire is high
`include "assert_macros.svh"

module lrd_framer import lrd_pkg::*; #(
	parameter int unsigned OFFSET_BITS = 48
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        fire,
	input  item_t       item,
	input  logic [31:0] max_len,
	output bundle_t     bundle
);

	logic [1:0]             phase_q;
	logic [2:0]             hdr_cnt_q;
	logic [31:0]            exp_crc_q;
	logic [31:0]            len_q;
	logic [31:0]            crc_q;
	logic [31:0]            pay_cnt_q;
	logic [OFFSET_BITS-1:0] offset_q;
	logic [31:0]            records_q;
	logic                   trunc_q;
	logic                   disc_q;

	logic [1:0]             n_phase;
	logic [2:0]             n_hdr_cnt;
	logic [31:0]            n_exp_crc;
	logic [31:0]            n_len;
	logic [31:0]            n_crc;
	logic [31:0]            n_pay_cnt;
	logic [OFFSET_BITS-1:0] n_offset;
	logic [31:0]            n_records;
	logic                   n_trunc;
	logic                   n_disc;

	function automatic logic [47:0] vb48(input logic [OFFSET_BITS-1:0] o);
		logic [63:0] w;
		w = 64'(o);
		return w[47:0];
	endfunction

	// Next state and results for the current item
	always_comb begin
		logic [1:0] k;
		logic       sum_tr;
		logic       sum_di;
		logic       do_finish;
		n_phase   = phase_q;
		n_hdr_cnt = hdr_cnt_q;
		n_exp_crc = exp_crc_q;
		n_len     = len_q;
		n_crc     = crc_q;
		n_pay_cnt = pay_cnt_q;
		n_offset  = offset_q;
		n_records = records_q;
		n_trunc   = trunc_q;
		n_disc    = disc_q;
		bundle    = '0;
		k         = 2'd0;
		do_finish = 1'b0;
		sum_tr    = 1'b0;
		sum_di    = 1'b0;

		if (item.present) begin
			unique case (phase_q)
				PH_HEADER: begin
					// CRC bytes first, then length bytes which also feed the CRC
					if (!hdr_cnt_q[2]) begin
						n_exp_crc = exp_crc_q | (32'(item.data) << {hdr_cnt_q[1:0], 3'b000});
					end else begin
						n_len = len_q | (32'(item.data) << {hdr_cnt_q[1:0], 3'b000});
						n_crc = crc_byte(crc_q, item.data);
					end
					n_hdr_cnt = hdr_cnt_q + 3'd1;
					if (hdr_cnt_q == 3'(HDR_BYTES - 1)) begin
						if (n_len > max_len) begin
							bundle.res[k] = mk_res(KIND_REJECT, 8'd0, n_len, vb48(n_offset),
								n_records, 1'b0, 1'b0);
							k         = k + 2'd1;
							n_trunc   = 1'b1;
							n_disc    = 1'b1;
							n_phase   = PH_REJECTED;
							n_hdr_cnt = 3'd0;
							n_exp_crc = '0;
							n_len     = '0;
							n_crc     = CRC_INIT;
							n_pay_cnt = '0;
						end else if (n_len == 32'd0) begin
							do_finish = 1'b1;
						end else begin
							n_phase = PH_PAYLOAD;
						end
					end
				end
				PH_PAYLOAD: begin
					// Pass the byte on tentatively
					bundle.res[k] = mk_res(KIND_PAYLOAD, item.data, 32'd0, vb48(n_offset),
						n_records, 1'b0, 1'b0);
					k         = k + 2'd1;
					n_crc     = crc_byte(crc_q, item.data);
					n_pay_cnt = pay_cnt_q + 32'd1;
					if (n_pay_cnt >= len_q) begin
						do_finish = 1'b1;
					end
				end
				PH_REJECTED: begin
					// Ignored until end of log
				end
				default: begin
				end
			endcase
		end

		// End of record: compare the CRC and mark accept or reject
		if (do_finish) begin
			if (~n_crc == n_exp_crc) begin
				n_offset  = n_offset + OFFSET_BITS'(n_len) + OFFSET_BITS'(HDR_BYTES);
				n_records = n_records + 32'd1;
				bundle.res[k] = mk_res(KIND_ACCEPT, 8'd0, n_len, vb48(n_offset),
					n_records, 1'b0, 1'b0);
				n_phase = PH_HEADER;
			end else begin
				bundle.res[k] = mk_res(KIND_REJECT, 8'd0, n_len, vb48(n_offset),
					n_records, 1'b0, 1'b0);
				n_trunc = 1'b1;
				n_disc  = 1'b1;
				n_phase = PH_REJECTED;
			end
			k         = k + 2'd1;
			n_hdr_cnt = 3'd0;
			n_exp_crc = '0;
			n_len     = '0;
			n_crc     = CRC_INIT;
			n_pay_cnt = '0;
		end

		// End of log summary, then back to a fresh log
		if (item.last) begin
			sum_tr = n_trunc;
			sum_di = n_disc;
			if (n_phase == PH_HEADER && n_hdr_cnt != 3'd0) begin
				sum_tr = 1'b1;
			end
			if (n_phase == PH_PAYLOAD) begin
				sum_tr = 1'b1;
				sum_di = 1'b1;
			end
			bundle.res[k] = mk_res(KIND_SUMMARY, 8'd0, 32'd0, vb48(n_offset),
				n_records, sum_tr, sum_di);
			k         = k + 2'd1;
			n_phase   = PH_HEADER;
			n_hdr_cnt = 3'd0;
			n_exp_crc = '0;
			n_len     = '0;
			n_crc     = CRC_INIT;
			n_pay_cnt = '0;
			n_offset  = '0;
			n_records = '0;
			n_trunc   = 1'b0;
			n_disc    = 1'b0;
		end

		if (k != 2'd0) begin
			bundle.res[k - 2'd1].run_last = 1'b1;
		end
		bundle.cnt = k;
	end

	// State registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= PH_HEADER;
			hdr_cnt_q <= '0;
			exp_crc_q <= '0;
			len_q     <= '0;
			crc_q     <= CRC_INIT;
			pay_cnt_q <= '0;
			offset_q  <= '0;
			records_q <= '0;
			trunc_q   <= 1'b0;
			disc_q    <= 1'b0;
		end else if (fire) begin
			phase_q   <= n_phase;
			hdr_cnt_q <= n_hdr_cnt;
			exp_crc_q <= n_exp_crc;
			len_q     <= n_len;
			crc_q     <= n_crc;
			pay_cnt_q <= n_pay_cnt;
			offset_q  <= n_offset;
			records_q <= n_records;
			trunc_q   <= n_trunc;
			disc_q    <= n_disc;
		end
	end

	`LRD_ASSERT(a_hdr_only_in_header, clk, arst_n, (hdr_cnt_q == 3'd0) || (phase_q == PH_HEADER))
	`LRD_ASSERT(a_pay_below_len, clk, arst_n, (phase_q != PH_PAYLOAD) || (pay_cnt_q < len_q))

endmodule

@@ hdl/lrd_res_queue.sv @@
// Result buffer: takes a bundle of up to three results, sends them one per transfer
`include "assert_macros.svh"

module lrd_res_queue import lrd_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    load,
	input  bundle_t bundle,
	output logic    can_load,
	output logic    out_valid,
	input  logic    out_stall,
	output res_t    head
);

	res_t [2:0] buf_q;
	logic [1:0] cnt_q;
	logic       take;

	assign out_valid = (cnt_q != 2'd0);
	assign take      = out_valid && !out_stall;
	assign can_load  = (cnt_q == 2'd0) || ((cnt_q == 2'd1) && take);
	assign head      = buf_q[0];

	// Result entries, shifted towards the head on each transfer
	always_ff @(posedge clk) begin
		if (load) begin
			buf_q <= bundle.res;
		end else if (take) begin
			buf_q[0] <= buf_q[1];
			buf_q[1] <= buf_q[2];
		end
	end

	// Occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (load) begin
			cnt_q <= bundle.cnt;
		end else if (take) begin
			cnt_q <= cnt_q - 2'd1;
		end
	end

	`LRD_ASSERT(a_last_on_final, clk, arst_n, (cnt_q != 2'd1) || buf_q[0].run_last)
	`LRD_ASSERT(a_no_early_last, clk, arst_n, (cnt_q == 2'd0) || (cnt_q == 2'd1) || !buf_q[0].run_last)

endmodule

@@ hdl/log_record_deframer_crc32c.sv @@
// Top level of the log record deframer with CRC32C check
// One log byte is taken per cycle into an input register when not stalled; the framer
// works the whole item in a single pass and loads its results (a payload byte, an accept
// or reject marker, the end-of-log summary: up to three) into the result buffer. The
// output port sends one result per cycle when not stalled; the input stalls while the
// buffer holds two or more results, or one not taken, so items with at most one result
// flow at one per cycle unless the output stalls. The cap register is always ready and
// must only be written while the block is idle.
`include "assert_macros.svh"

module log_record_deframer_crc32c import lrd_pkg::*; #(
	parameter int unsigned OFFSET_BITS = 48
) (
	input  logic        clk,
	input  logic        arst_n,
	// input channel
	input  logic        in_valid,
	output logic        in_stall,
	input  logic        byte_present,
	input  logic [7:0]  in_byte,
	input  logic        end_of_log,
	// configuration channel
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [31:0] cfg_data,
	// output channel
	output logic        out_valid,
	input  logic        out_stall,
	output logic [1:0]  kind,
	output logic [7:0]  payload_byte,
	output logic [31:0] record_length,
	output logic [47:0] accepted_bytes,
	output logic [31:0] record_count,
	output logic        truncated,
	output logic        discarded,
	output logic        run_last
);

	logic        s1_valid_q;
	item_t       item_s1;
	logic [31:0] max_len_q;
	logic        can_load;
	logic        fire;
	bundle_t     bundle;
	res_t        head;

	// Cap register
	assign cfg_ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_len_q <= DEFAULT_CAP;
		end else if (cfg_valid && cfg_ready) begin
			max_len_q <= cfg_data;
		end
	end

	// Input register
	assign fire     = s1_valid_q && can_load;
	assign in_stall = s1_valid_q && !can_load;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
		end else if (!in_stall) begin
			s1_valid_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			item_s1 <= '{present: byte_present, data: in_byte, last: end_of_log};
		end
	end

	lrd_framer #(
		.OFFSET_BITS(OFFSET_BITS)
	) u_framer (
		.clk    (clk),
		.arst_n (arst_n),
		.fire   (fire),
		.item   (item_s1),
		.max_len(max_len_q),
		.bundle (bundle)
	);

	lrd_res_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.load     (fire),
		.bundle   (bundle),
		.can_load (can_load),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.head     (head)
	);

	// Result fields
	assign kind           = head.kind;
	assign payload_byte   = head.payload_byte;
	assign record_length  = head.record_length;
	assign accepted_bytes = head.accepted_bytes;
	assign record_count   = head.record_count;
	assign truncated      = head.truncated;
	assign discarded      = head.discarded;
	assign run_last       = head.run_last;

	`LRD_ASSERT_NEXT(a_stall_holds_item, clk, arst_n, in_stall, s1_valid_q)

endmodule
